/* hdl/psf_pkg.sv */
// Package for the polygon scanline span fill block.
// Holds command and register codes, clip reset values, fixed-point widths and sizing defaults.
// No dependencies.
package psf_pkg;

  // Input commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SCAN   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic REG_CLIP_MIN = 1'b0;
  localparam logic REG_CLIP_MAX = 1'b1;

  // Reset values of the clip window
  localparam logic signed [15:0] CLIP_MIN_RESET = 16'sd0;
  localparam logic signed [15:0] CLIP_MAX_RESET = 16'sd32767;

  // Sizing defaults
  localparam int MAX_VERTICES_DEF = 64;

  // Fixed-point format of vertex coordinates
  localparam int FRAC = 8;
  localparam int VW   = 24;                       // vertex coordinate width
  localparam int RW   = 16;                       // row and span coordinate width
  localparam int YW   = ((VW > RW + FRAC) ? VW : RW + FRAC) + 1;  // y differences
  localparam int DXW  = VW + 1;                   // x differences
  localparam int PW   = YW + DXW + 2;             // cross-product accumulator
  localparam int QB   = VW - FRAC + 1;            // quotient magnitude bits
  localparam int CW   = QB;                       // stored crossing width (signed)

endpackage

/* hdl/polygon_scanline_span_fill.sv */
// Polygon scanline span fill, even-odd rule, with a horizontal clip window.
// Depends on psf_pkg for command codes, register codes and fixed-point widths.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  in       | input     | in_valid/in_stall   | command, vertex_x, vertex_y, row_y
//  out      | output    | out_valid/out_stall | span_start_x, span_row, span_width,
//           |           |                     | span_valid, last_span
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Clear and append complete in the idle state. A scan walks the stored edges; each
// crossing passes a 25-step shift-add multiplier and a 17-step restoring divider
// that share nothing with each other, then an insertion sort into the crossing buffer;
// the crossing pairs are then clipped and emitted as results. The registered read of
// the crossing buffer and the serial arithmetic set the pace of a scan.
// Reset is synchronous and empties the vertex list and restores the clip window.
// A stalled result waits in the output register; the block then returns to idle and
// takes the next transaction while the last result of a row is still held.
module polygon_scanline_span_fill #(
  parameter int MAX_VERTICES = psf_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [23:0] vertex_x,
  input  logic signed [23:0] vertex_y,
  input  logic signed [15:0] row_y,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] span_start_x,
  output logic signed [15:0] span_row,
  output logic [15:0]        span_width,
  output logic               span_valid,
  output logic               last_span,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int VW   = psf_pkg::VW;
  localparam int YW   = psf_pkg::YW;
  localparam int DXW  = psf_pkg::DXW;
  localparam int PW   = psf_pkg::PW;
  localparam int QB   = psf_pkg::QB;
  localparam int CW   = psf_pkg::CW;
  localparam int MW   = YW;
  localparam int MCW  = $clog2(MW);
  localparam int DCW  = $clog2(QB);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PREV  = 15'b000000000000010,
    S_VWAIT = 15'b000000000000100,
    S_EDGE  = 15'b000000000001000,
    S_MUL   = 15'b000000000010000,
    S_DSET  = 15'b000000000100000,
    S_DIV   = 15'b000000001000000,
    S_IWAIT = 15'b000000010000000,
    S_ICMP  = 15'b000000100000000,
    S_IPUT  = 15'b000001000000000,
    S_ECHK  = 15'b000010000000000,
    S_ES    = 15'b000100000000000,
    S_EE    = 15'b001000000000000,
    S_EOUT  = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t st;

  // Vertex memory: x in the upper half of each word, y in the lower half.
  logic [2*VW-1:0] vmem [MAX_VERTICES];
  logic [2*VW-1:0] vq;
  logic [AW-1:0]   vra;
  logic            vwe;

  // Crossing buffer memory.
  logic signed [CW-1:0] cmem [MAX_VERTICES];
  logic signed [CW-1:0] cq;
  logic signed [CW-1:0] cwd;
  logic [AW-1:0]        cra;
  logic [AW-1:0]        cwa;
  logic                 cwe;

  // Control and datapath registers.
  logic [CNTW-1:0]       vcount;
  logic [CNTW-1:0]       ncross;
  logic [AW-1:0]         ei;
  logic [CNTW-1:0]       k;
  logic [CNTW-1:0]       p;
  logic signed [15:0]    clip_min;
  logic signed [15:0]    clip_max;
  logic signed [15:0]    row;
  logic signed [VW-1:0]  bx;
  logic signed [VW-1:0]  by;
  logic signed [PW-1:0]  acc;
  logic signed [PW-1:0]  mca;
  logic signed [PW-1:0]  mcb;
  logic [MW-1:0]         mla;
  logic [MW-1:0]         mlb;
  logic [MCW-1:0]        mcnt;
  logic                  den_neg;
  logic [YW-1:0]         den_abs;
  logic [PW-1:0]         rem;
  logic [PW-1:0]         dsr;
  logic [QB-1:0]         qm;
  logic [DCW-1:0]        dcnt;
  logic                  nsgn;
  logic signed [CW-1:0]  qv;
  logic signed [CW-1:0]  sv;
  logic                  pend_v;
  logic signed [15:0]    pend_s;
  logic [15:0]           pend_w;
  logic signed [15:0]    cand_s;
  logic [15:0]           cand_w;

  // Combinational helpers.
  logic                  accept;
  logic                  ofree;
  logic                  oload;
  logic signed [VW-1:0]  ax;
  logic signed [VW-1:0]  ay;
  logic signed [YW-1:0]  ry;
  logic signed [YW-1:0]  ya;
  logic signed [YW-1:0]  yb;
  logic signed [YW-1:0]  den;
  logic signed [YW-1:0]  dy;
  logic signed [DXW-1:0] dxw;
  logic                  crosses;
  logic                  last_edge;
  logic                  mlast;
  logic signed [PW-1:0]  ta;
  logic signed [PW-1:0]  tb;
  logic signed [PW-1:0]  numf;
  logic                  ge;
  logic [QB-1:0]         qm_next;
  logic                  cgt;
  logic [CNTW-1:0]       km1;
  logic [CNTW:0]         p_end;
  logic signed [CW-1:0]  cmin_e;
  logic signed [CW-1:0]  cmax_e;
  logic signed [CW-1:0]  s_clip;
  logic signed [CW-1:0]  e_clip;
  logic signed [CW-1:0]  w_raw;
  logic [15:0]           w_sat;

  function automatic logic [AW-1:0] km1_v(input logic [CNTW-1:0] c);
    logic [CNTW-1:0] d;
    d = c - 1'b1;
    return d[AW-1:0];
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (st != S_IDLE);
  assign cfg_ready = 1'b1;
  assign ofree     = !out_valid || !out_stall;
  // A result is loaded into the output register only from the emit states.
  assign oload     = ofree && ((st == S_EOUT) || (st == S_FIN));

  // Edge geometry: vertex a comes from the memory, vertex b is the one before it.
  assign ax        = vq[2*VW-1:VW];
  assign ay        = vq[VW-1:0];
  assign ry        = YW'(row) <<< psf_pkg::FRAC;
  assign ya        = YW'(ay);
  assign yb        = YW'(by);
  assign den       = yb - ya;
  assign dy        = ry - ya;
  assign dxw       = DXW'(bx) - DXW'(ax);
  // Half-open test; a horizontal edge never passes it.
  assign crosses   = ((ya < ry) && (yb >= ry)) || ((yb < ry) && (ya >= ry));
  assign last_edge = (CNTW'(ei) == (vcount - 1'b1));

  // Signed shift-add multiply: the top multiplier bit carries negative weight.
  assign mlast = (mcnt == MCW'(MW - 1));
  assign ta    = mla[0] ? (mlast ? -mca : mca) : '0;
  assign tb    = mlb[0] ? (mlast ? -mcb : mcb) : '0;
  assign numf  = den_neg ? -acc : acc;

  // Restoring divide of the magnitudes, one quotient bit per cycle.
  assign ge      = (rem >= dsr);
  assign qm_next = {qm[QB-2:0], ge};

  assign cgt   = (cq > qv);
  assign km1   = k - 1'b1;
  assign p_end = {1'b0, p} + (CNTW+1)'(2);

  // Span clipping.
  assign cmin_e = CW'(clip_min);
  assign cmax_e = CW'(clip_max);
  assign s_clip = (sv < cmin_e) ? cmin_e : sv;
  assign e_clip = (cq > cmax_e) ? cmax_e : cq;
  assign w_raw  = e_clip - s_clip;
  assign w_sat  = w_raw[CW-1] ? 16'd0 : w_raw[15:0];

  // Memory addressing.
  assign vwe = accept && (command == psf_pkg::CMD_APPEND) &&
               (vcount < CNTW'(MAX_VERTICES));
  assign vra = (st == S_IDLE) ? km1_v(vcount) : ei;

  always_comb begin
    case (st)
      S_ECHK:  cra = p[AW-1:0];
      S_ES:    cra = km1_v(p + CNTW'(2));
      default: cra = km1[AW-1:0];
    endcase
  end

  assign cwe = (st == S_ICMP) || (st == S_IPUT);
  assign cwa = k[AW-1:0];
  assign cwd = ((st == S_ICMP) && cgt) ? cq : qv;

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vcount[AW-1:0]] <= {vertex_x, vertex_y};
    end
    vq <= vmem[vra];
  end

  always_ff @(posedge clk) begin
    if (cwe) begin
      cmem[cwa] <= cwd;
    end
    cq <= cmem[cra];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_min <= psf_pkg::CLIP_MIN_RESET;
      clip_max <= psf_pkg::CLIP_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psf_pkg::REG_CLIP_MIN: clip_min <= cfg_data;
        psf_pkg::REG_CLIP_MAX: clip_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      vcount    <= '0;
      ncross    <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (oload) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            case (command)
              psf_pkg::CMD_CLEAR: vcount <= '0;
              psf_pkg::CMD_APPEND: begin
                if (vwe) begin
                  vcount <= vcount + 1'b1;
                end
              end
              psf_pkg::CMD_SCAN: begin
                row    <= row_y;
                ncross <= '0;
                ei     <= '0;
                p      <= '0;
                pend_v <= 1'b0;
                st     <= (vcount == '0) ? S_ECHK : S_PREV;
              end
              default: ;
            endcase
          end
        end
        S_PREV: begin
          // The closing edge starts from the last stored vertex.
          bx <= ax;
          by <= ay;
          st <= S_EDGE;
        end
        S_VWAIT: st <= S_EDGE;
        S_EDGE: begin
          if (crosses) begin
            mca     <= PW'(ax);
            mcb     <= PW'(dxw);
            mla     <= den;
            mlb     <= dy;
            acc     <= '0;
            mcnt    <= '0;
            den_neg <= den[YW-1];
            den_abs <= den[YW-1] ? -den : den;
            st      <= S_MUL;
          end else begin
            bx <= ax;
            by <= ay;
            if (last_edge) begin
              st <= S_ECHK;
            end else begin
              ei <= ei + 1'b1;
              st <= S_VWAIT;
            end
          end
        end
        S_MUL: begin
          acc  <= acc + ta + tb;
          mca  <= mca <<< 1;
          mcb  <= mcb <<< 1;
          mla  <= mla >> 1;
          mlb  <= mlb >> 1;
          mcnt <= mcnt + 1'b1;
          if (mlast) begin
            st <= S_DSET;
          end
        end
        S_DSET: begin
          nsgn <= numf[PW-1];
          rem  <= numf[PW-1] ? -numf : numf;
          dsr  <= PW'(den_abs) << (psf_pkg::FRAC + QB - 1);
          qm   <= '0;
          dcnt <= '0;
          st   <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - dsr;
          end
          qm   <= qm_next;
          dsr  <= dsr >> 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(QB - 1)) begin
            qv <= nsgn ? (~qm_next + 1'b1) : qm_next;
            k  <= ncross;
            st <= (ncross == '0) ? S_IPUT : S_IWAIT;
          end
        end
        S_IWAIT: st <= S_ICMP;
        S_ICMP: begin
          if (cgt) begin
            // Entry k-1 moved up one place; keep searching below it.
            k  <= km1;
            st <= (k == CNTW'(1)) ? S_IPUT : S_IWAIT;
          end else begin
            ncross <= ncross + 1'b1;
            bx     <= ax;
            by     <= ay;
            if (last_edge) begin
              st <= S_ECHK;
            end else begin
              ei <= ei + 1'b1;
              st <= S_VWAIT;
            end
          end
        end
        S_IPUT: begin
          ncross <= ncross + 1'b1;
          bx     <= ax;
          by     <= ay;
          if (last_edge) begin
            st <= S_ECHK;
          end else begin
            ei <= ei + 1'b1;
            st <= S_VWAIT;
          end
        end
        S_ECHK: st <= (p_end <= {1'b0, ncross}) ? S_ES : S_FIN;
        S_ES: begin
          sv <= cq;
          st <= S_EE;
        end
        S_EE: begin
          if (sv > cmax_e) begin
            st <= S_FIN;
          end else if (cq > cmin_e) begin
            if (!pend_v) begin
              pend_v <= 1'b1;
              pend_s <= s_clip[15:0];
              pend_w <= w_sat;
              p      <= p + CNTW'(2);
              st     <= S_ECHK;
            end else begin
              cand_s <= s_clip[15:0];
              cand_w <= w_sat;
              st     <= S_EOUT;
            end
          end else begin
            p  <= p + CNTW'(2);
            st <= S_ECHK;
          end
        end
        S_EOUT: begin
          // A later span exists, so the held one is not the last of the row.
          if (ofree) begin
            span_start_x <= pend_s;
            span_row     <= row;
            span_width   <= pend_w;
            span_valid   <= 1'b1;
            last_span    <= 1'b0;
            pend_s       <= cand_s;
            pend_w       <= cand_w;
            p            <= p + CNTW'(2);
            st           <= S_ECHK;
          end
        end
        S_FIN: begin
          if (ofree) begin
            span_row   <= row;
            span_valid <= pend_v;
            last_span  <= 1'b1;
            if (pend_v) begin
              span_start_x <= pend_s;
              span_width   <= pend_w;
            end else begin
              span_start_x <= '0;
              span_width   <= '0;
            end
            pend_v <= 1'b0;
            st     <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= CNTW'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_cross_bound: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> (ncross <= vcount))
    else $error("more crossings than edges");

  a_load_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(st) == S_EOUT || $past(st) == S_FIN))
    else $error("result loaded outside the emit states");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !span_valid |-> last_span)
    else $error("empty row result without last mark");

  a_ins_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_ICMP) |-> (k != '0))
    else $error("insertion compare below the first entry");

endmodule

/* tb/polygon_scanline_span_fill_tb.sv */
// Testbench for the polygon scanline span fill block: directed and random polygons,
// scanned rows and clip windows, checked against an even-odd span predictor.
// Depends on psf_pkg and the polygon_scanline_span_fill RTL.
`timescale 1ns / 100ps

typedef struct {
  logic signed [15:0] start_x;
  logic signed [15:0] row;
  logic [15:0]        width;
  logic               present;
  logic               last;
} span_t;

// Span scoreboard: keeps its own vertex list and clip window, predicts the spans
// of each scan transaction and matches them in order against the block's results.
class span_scoreboard;
  logic signed [23:0] vx[64];
  logic signed [23:0] vy[64];
  int                 nverts;
  logic signed [15:0] clip_lo;
  logic signed [15:0] clip_hi;
  span_t              pending[$];
  int                 errors;

  function new();
    nverts  = 0;
    clip_lo = psf_pkg::CLIP_MIN_RESET;
    clip_hi = psf_pkg::CLIP_MAX_RESET;
    errors  = 0;
  endfunction

  function void note_clip(logic idx, logic [15:0] data);
    if (idx == psf_pkg::REG_CLIP_MIN) clip_lo = data;
    else clip_hi = data;
  endfunction

  // Note one accepted input transaction and queue the spans it must produce.
  function void note_input(logic [1:0] cmd, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [15:0] ry);
    longint xs[$];
    longint ya, yb, xa, xb, yr, den, num, s, e, w, t;
    int j, k, cnt;
    span_t sp;
    if (cmd == psf_pkg::CMD_CLEAR) begin
      nverts = 0;
    end else if (cmd == psf_pkg::CMD_APPEND) begin
      if (nverts < 64) begin
        vx[nverts] = x;
        vy[nverts] = y;
        nverts++;
      end
    end else if (cmd == psf_pkg::CMD_SCAN) begin
      yr = longint'(ry) * 256;
      j = (nverts > 0) ? nverts - 1 : 0;
      for (int i = 0; i < nverts; i++) begin
        xa = vx[i]; ya = vy[i]; xb = vx[j]; yb = vy[j];
        if ((ya < yr && yb >= yr) || (yb < yr && ya >= yr)) begin
          den = yb - ya;
          num = xa * den + (yr - ya) * (xb - xa);
          if (den < 0) begin
            den = -den;
            num = -num;
          end
          xs = {xs, num / (den * 256)};  // SV division truncates toward zero
        end
        j = i;
      end
      for (int i = 1; i < xs.size(); i++) begin
        t = xs[i];
        k = i;
        while (k > 0 && xs[k-1] > t) begin
          xs[k] = xs[k-1];
          k--;
        end
        xs[k] = t;
      end
      cnt = 0;
      for (int i = 0; i + 1 < xs.size(); i += 2) begin
        s = xs[i];
        e = xs[i+1];
        if (s > clip_hi) break;
        if (e > clip_lo) begin
          if (s < clip_lo) s = clip_lo;
          if (e > clip_hi) e = clip_hi;
          w = e - s;
          if (w < 0) w = 0;
          sp.start_x = s[15:0];
          sp.row     = ry;
          sp.width   = w[15:0];
          sp.present = 1'b1;
          sp.last    = 1'b0;
          pending = {pending, sp};
          cnt++;
        end
      end
      if (cnt == 0) begin
        sp.start_x = '0;
        sp.row     = ry;
        sp.width   = '0;
        sp.present = 1'b0;
        sp.last    = 1'b1;
        pending = {pending, sp};
      end else begin
        pending[pending.size()-1].last = 1'b1;
      end
    end
  endfunction

  // Check one accepted result against the oldest expected span.
  function void check_span(span_t got);
    span_t want;
    if (pending.size() == 0) begin
      $error("unexpected span result: start %0d row %0d", got.start_x, got.row);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.start_x !== want.start_x) begin
      $error("span_start_x expected %0d actual %0d", want.start_x, got.start_x);
      errors++;
    end
    if (got.row !== want.row) begin
      $error("span_row expected %0d actual %0d", want.row, got.row);
      errors++;
    end
    if (got.width !== want.width) begin
      $error("span_width expected %0d actual %0d", want.width, got.width);
      errors++;
    end
    if (got.present !== want.present) begin
      $error("span_valid expected %0d actual %0d", want.present, got.present);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last_span expected %0d actual %0d", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module polygon_scanline_span_fill_tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic signed [23:0] vertex_x;
  logic signed [23:0] vertex_y;
  logic signed [15:0] row_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] span_start_x;
  logic signed [15:0] span_row;
  logic [15:0]        span_width;
  logic               span_valid;
  logic               last_span;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;

  // Idle percentages for the sender and the receiver; changed between phases.
  int send_idle_pct;
  int recv_idle_pct;
  // When set, the receiver holds stall high for this many cycles once.
  int hold_off_cycles;

  span_scoreboard board;

  polygon_scanline_span_fill u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .row_y        (row_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .span_start_x (span_start_x),
    .span_row     (span_row),
    .span_width   (span_width),
    .span_valid   (span_valid),
    .last_span    (last_span),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is bounded by a generous fixed time: the whole run, with every item at its
  // worst (a full list of 64 vertices with every edge crossing, a full insertion sort, long receiver stalls), stays
  // well below this.
  initial begin
    #500ms;
    $display("tb: failure");
    $finish;
  end

  // Receiver: stall is changed at the falling edge, results sampled at the rising edge.
  // A requested hold-off keeps stall high for a counted stretch so the block backs up.
  initial begin
    span_t got;
    int    hold_left;
    bit    hold_taken;
    out_stall = 1'b1;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.start_x = span_start_x;
        got.row     = span_row;
        got.width   = span_width;
        got.present = span_valid;
        got.last    = last_span;
        board.check_span(got);
      end
      @(negedge clk);
      if (!hold_taken && hold_off_cycles > 0) begin
        hold_left = hold_off_cycles;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one input transaction and wait until it is accepted. The valid is held
  // across back-to-back transactions; only an idle gap lowers it.
  task automatic send_item(logic [1:0] cmd, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [15:0] ry);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    vertex_x <= x;
    vertex_y <= y;
    row_y    <= ry;
    do @(posedge clk); while (in_stall);
    board.note_input(cmd, x, y, ry);
    @(negedge clk);
  endtask

  // Let the block drain: all expected spans arrive, then a pause for the block
  // to finish any transaction that produces no result.
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 2000000) begin
      @(negedge clk);
      guard++;
    end
    repeat (400) @(negedge clk);
  endtask

  // Write one clip register while the block is idle.
  task automatic write_clip(logic idx, logic signed [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.note_clip(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_vertex(int x, int y);
    send_item(psf_pkg::CMD_APPEND, 24'(x), 24'(y), 16'sd0);
  endtask

  // A random vertex: mostly within a small window so rows hit the polygon,
  // sometimes anywhere in the full Q16.8 range.
  task automatic random_vertex();
    if ($urandom_range(9) == 0)
      add_vertex($urandom, $urandom);
    else
      add_vertex($signed($urandom_range(40 * 256)) - 20 * 256,
                 $signed($urandom_range(40 * 256)) - 20 * 256);
  endtask

  task automatic random_scan();
    if ($urandom_range(9) == 0)
      send_item(psf_pkg::CMD_SCAN, 24'($urandom), 24'($urandom), 16'($urandom));
    else
      send_item(psf_pkg::CMD_SCAN, 24'($urandom), 24'($urandom),
                16'($signed($urandom_range(44)) - 22));
  endtask

  // One random polygon with a few scans of it; occasionally noise commands.
  task automatic random_polygon(ref int sent);
    int nv;
    nv = ($urandom_range(15) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 3);
    send_item(psf_pkg::CMD_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom));
    sent++;
    for (int v = 0; v < nv; v++) begin
      random_vertex();
      sent++;
    end
    for (int q = $urandom_range(5, 1); q > 0; q--) begin
      if ($urandom_range(7) == 0) begin
        send_item(psf_pkg::CMD_UNUSED, 24'($urandom), 24'($urandom), 16'($urandom));
        sent++;
      end
      random_scan();
      sent++;
    end
  endtask

  task automatic random_phase(int items);
    int sent;
    sent = 0;
    while (sent < items) random_polygon(sent);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    command = psf_pkg::CMD_CLEAR;
    vertex_x = '0;
    vertex_y = '0;
    row_y = '0;
    cfg_valid = 1'b0;
    cfg_index = psf_pkg::REG_CLIP_MIN;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: scan of an empty list, a diamond with a vertex on the row
    // (half-open test), a horizontal edge, a triangle with extreme coordinates,
    // an unused command code.
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd0);
    add_vertex(0, -10 * 256);
    add_vertex(10 * 256, 0);
    add_vertex(0, 10 * 256);
    add_vertex(-10 * 256, 0);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd0);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd5);
    send_item(psf_pkg::CMD_SCAN, '0, '0, -16'sd10);
    send_item(psf_pkg::CMD_UNUSED, 24'h7FFFFF, 24'h800000, 16'sh7FFF);
    send_item(psf_pkg::CMD_CLEAR, '0, '0, '0);
    add_vertex(2 * 256 + 128, 0);
    add_vertex(30 * 256, 0);
    add_vertex(30 * 256, 5 * 256);
    add_vertex(2 * 256, 5 * 256);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd0);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd3);
    send_item(psf_pkg::CMD_CLEAR, '0, '0, '0);
    send_item(psf_pkg::CMD_APPEND, 24'sh7FFFFF, 24'sh800000, 16'sd0);
    send_item(psf_pkg::CMD_APPEND, 24'sh800000, 24'sh7FFFFF, 16'sd0);
    send_item(psf_pkg::CMD_APPEND, 24'sh800000, 24'sh800000, 16'sd0);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sh8000);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd32767);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd0);
    drain();

    // Inverted and extreme clip windows on a fixed polygon.
    write_clip(psf_pkg::REG_CLIP_MIN, 16'sh8000);
    write_clip(psf_pkg::REG_CLIP_MAX, 16'sh8000);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd0);
    drain();
    write_clip(psf_pkg::REG_CLIP_MIN, 16'sd32767);
    write_clip(psf_pkg::REG_CLIP_MAX, 16'sd5);
    send_item(psf_pkg::CMD_SCAN, '0, '0, 16'sd0);
    drain();

    // Random phases: sender idles rarely and receiver often, then the reverse.
    write_clip(psf_pkg::REG_CLIP_MIN, -16'sd8);
    write_clip(psf_pkg::REG_CLIP_MAX, 16'sd8);
    send_idle_pct = 8;
    recv_idle_pct = 85;
    random_phase(140);
    drain();

    write_clip(psf_pkg::REG_CLIP_MIN, 16'sh8000);
    write_clip(psf_pkg::REG_CLIP_MAX, 16'sd32767);
    send_idle_pct = 85;
    recv_idle_pct = 8;
    random_phase(140);
    drain();

    // No idling, with one long receiver hold-off so the block backs up.
    write_clip(psf_pkg::REG_CLIP_MIN, 16'($signed($urandom_range(20)) - 10));
    write_clip(psf_pkg::REG_CLIP_MAX, 16'($signed($urandom_range(30)) - 5));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 3000;
    random_phase(140);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      if (board.pending.size() != 0)
        $error("%0d expected spans never arrived", board.pending.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/psf_pkg.sv
hdl/polygon_scanline_span_fill.sv
tb/polygon_scanline_span_fill_tb.sv
